// ----- rtl/core/ipd_pkg.sv -----
`timescale 1ns / 1ps

package ipd_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_SETPOINT   = 3'd0;
    localparam logic [2:0] CFG_ERROR_GATE = 3'd1;
    localparam logic [2:0] CFG_GAIN_P     = 3'd2;
    localparam logic [2:0] CFG_GAIN_I     = 3'd3;
    localparam logic [2:0] CFG_GAIN_D     = 3'd4;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // register reset values
    localparam logic [7:0] SETPOINT_RST   = 8'd171;
    localparam logic [5:0] ERROR_GATE_RST = 6'd20;
    localparam logic [7:0] GAIN_P_RST     = 8'd3;
    localparam logic [7:0] GAIN_I_RST     = 8'd1;
    localparam logic [7:0] GAIN_D_RST     = 8'd26;

    typedef struct packed {
        logic [5:0] error_gate;
        logic [7:0] gain_p;
        logic [7:0] gain_i;
        logic [7:0] gain_d;
    } pid_cfg_t;

    typedef struct packed {
        logic [5:0] err_now;
        logic [5:0] err_prev;
        logic [5:0] err_prev2;
    } err_hist_t;

    typedef struct packed {
        logic [7:0] tick_count;
        logic       enable_level;
    } pwm_state_t;

endpackage

// ----- rtl/core/ipd_pid.sv -----
`timescale 1ns / 1ps

module ipd_pid #(
    parameter int PWM_PERIOD = 20
) (
    input  logic [7:0]          err_mag,
    input  ipd_pkg::pid_cfg_t   cfg,
    input  ipd_pkg::err_hist_t  hist_in,
    input  logic [7:0]          drive_in,
    output ipd_pkg::err_hist_t  hist_out,
    output logic [7:0]          drive_out
);
    import ipd_pkg::*;

    localparam logic [7:0] PERIOD_W = 8'(PWM_PERIOD);

    logic        gated;
    logic [5:0]  e0, e1, e2;
    logic        de_pos;
    logic [5:0]  de_mag;
    logic [6:0]  two_e1, sum2;
    logic        d2_pos;
    logic [6:0]  d2_mag;
    logic [13:0] prod_p, prod_i;
    logic [14:0] prod_d;
    logic [16:0] pos, neg, diff;

    always_comb begin
        gated  = err_mag > {2'b00, cfg.error_gate};
        e0     = err_mag[5:0];
        e1     = hist_in.err_now;
        e2     = hist_in.err_prev;
        de_pos = e0 > e1;
        de_mag = de_pos ? (e0 - e1) : (e1 - e0);
        two_e1 = {e1, 1'b0};
        sum2   = {1'b0, e0} + {1'b0, e2};
        d2_pos = sum2 > two_e1;
        d2_mag = d2_pos ? (sum2 - two_e1) : (two_e1 - sum2);
        prod_p = cfg.gain_p * de_mag;
        prod_i = cfg.gain_i * e0;
        prod_d = cfg.gain_d * d2_mag;

        pos = {9'd0, drive_in} + {3'd0, prod_i}
            + (de_pos ? {3'd0, prod_p} : 17'd0)
            + (d2_pos ? {2'd0, prod_d} : 17'd0);
        neg = (de_pos ? 17'd0 : {3'd0, prod_p})
            + (d2_pos ? 17'd0 : {2'd0, prod_d});
        diff = pos - neg;

        if (gated) begin
            hist_out  = hist_in;
            drive_out = PERIOD_W;
        end else begin
            hist_out.err_now   = e0;
            hist_out.err_prev  = e1;
            hist_out.err_prev2 = e2;
            if (pos > neg) begin
                drive_out = (diff < {9'd0, PERIOD_W}) ? diff[7:0] : PERIOD_W;
            end else begin
                drive_out = drive_in;
            end
        end
    end

endmodule

// ----- rtl/core/ipd_pwm.sv -----
`timescale 1ns / 1ps

module ipd_pwm #(
    parameter int PWM_PERIOD = 20
) (
    input  ipd_pkg::pwm_state_t state_in,
    input  logic [7:0]          drive,
    output ipd_pkg::pwm_state_t state_out
);
    import ipd_pkg::*;

    localparam logic [7:0] PERIOD_W = 8'(PWM_PERIOD);

    logic [7:0] count_inc;
    logic       en_cmp;

    always_comb begin
        count_inc = state_in.tick_count + 8'd1;
        en_cmp    = count_inc <= drive;
        if (count_inc == PERIOD_W) begin
            state_out.tick_count   = 8'd0;
            state_out.enable_level = ~en_cmp;
        end else begin
            state_out.tick_count   = count_inc;
            state_out.enable_level = en_cmp;
        end
    end

endmodule

// ----- rtl/core/incremental_pid_pwm_motor_drive.sv -----
`timescale 1ns / 1ps
// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// input    | s_valid s_ready s_req_type s_sample     | in
// result   | m_valid m_ready m_enable m_forward      | out
//          | m_reverse m_duty                        |
// config   | cfg_wr_en cfg_index cfg_wdata           | in
//
// one item per cycle while the result register is free: each transfer is
// worked from the controller state and lands in the result register
// the result register is released by m_ready, so input is taken whenever
// the result register is empty or being emptied in that cycle
// synchronous active-low reset restores gains, history, drive and pwm counter

module incremental_pid_pwm_motor_drive #(
    parameter int PWM_PERIOD = 20
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_sample,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_enable,
    output logic       m_forward,
    output logic       m_reverse,
    output logic [7:0] m_duty,
    // configuration write port
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wdata
);
    import ipd_pkg::*;

    // configuration registers
    logic [7:0] setpoint_reg;
    pid_cfg_t   pid_cfg_reg;

    // controller state
    err_hist_t  hist_reg, hist_next;
    logic [7:0] drive_reg, drive_next;
    pwm_state_t pwm_reg, pwm_next;
    logic       fwd_reg, fwd_next;
    logic       rev_reg, rev_next;

    // result register
    logic       m_valid_reg;
    logic       m_enable_reg;
    logic       m_forward_reg;
    logic       m_reverse_reg;
    logic [7:0] m_duty_reg;

    logic       accept;
    logic       sp_ge;
    logic [7:0] err_mag;
    err_hist_t  pid_hist;
    logic [7:0] pid_drive;
    pwm_state_t tick_state;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;

    // error magnitude and direction from the sample
    assign sp_ge   = setpoint_reg >= s_sample;
    assign err_mag = sp_ge ? (setpoint_reg - s_sample) : (s_sample - setpoint_reg);

    ipd_pid #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_pid (
        .err_mag   (err_mag),
        .cfg       (pid_cfg_reg),
        .hist_in   (hist_reg),
        .drive_in  (drive_reg),
        .hist_out  (pid_hist),
        .drive_out (pid_drive)
    );

    ipd_pwm #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_pwm (
        .state_in  (pwm_reg),
        .drive     (drive_reg),
        .state_out (tick_state)
    );

    // next state: a sample runs the pid, a tick advances the pwm counter
    always_comb begin
        hist_next  = hist_reg;
        drive_next = drive_reg;
        pwm_next   = pwm_reg;
        fwd_next   = fwd_reg;
        rev_next   = rev_reg;
        if (accept) begin
            if (s_req_type == REQ_SAMPLE) begin
                hist_next  = pid_hist;
                drive_next = pid_drive;
                fwd_next   = sp_ge;
                rev_next   = ~sp_ge;
            end else begin
                pwm_next = tick_state;
            end
        end
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg           <= SETPOINT_RST;
            pid_cfg_reg.error_gate <= ERROR_GATE_RST;
            pid_cfg_reg.gain_p     <= GAIN_P_RST;
            pid_cfg_reg.gain_i     <= GAIN_I_RST;
            pid_cfg_reg.gain_d     <= GAIN_D_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SETPOINT:   setpoint_reg           <= cfg_wdata;
                CFG_ERROR_GATE: pid_cfg_reg.error_gate <= cfg_wdata[5:0];
                CFG_GAIN_P:     pid_cfg_reg.gain_p     <= cfg_wdata;
                CFG_GAIN_I:     pid_cfg_reg.gain_i     <= cfg_wdata;
                CFG_GAIN_D:     pid_cfg_reg.gain_d     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg             <= '0;
            drive_reg            <= 8'd0;
            pwm_reg.tick_count   <= 8'd0;
            pwm_reg.enable_level <= 1'b1;
            fwd_reg              <= 1'b0;
            rev_reg              <= 1'b0;
        end else begin
            hist_reg  <= hist_next;
            drive_reg <= drive_next;
            pwm_reg   <= pwm_next;
            fwd_reg   <= fwd_next;
            rev_reg   <= rev_next;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with the post-transfer state
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_enable_reg  <= pwm_next.enable_level;
            m_forward_reg <= fwd_next;
            m_reverse_reg <= rev_next;
            m_duty_reg    <= drive_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_enable  = m_enable_reg;
    assign m_forward = m_forward_reg;
    assign m_reverse = m_reverse_reg;
    assign m_duty    = m_duty_reg;

endmodule

// ----- tb/incremental_pid_pwm_motor_drive_test.sv -----
`timescale 1ns / 1ps

module incremental_pid_pwm_motor_drive_test;
    import ipd_pkg::*;

    localparam int PWM_PERIOD   = 20;
    localparam int N_DIRECTED   = 22;
    localparam int N_CFG_PHASES = 8;
    localparam int PHASE_ITEMS  = 115;
    localparam int MAX_REPORTS  = 10;

    // one result as it appears on the m_ side
    typedef struct packed {
        logic       enable;
        logic       forward;
        logic       reverse;
        logic [7:0] duty;
    } drive_out_t;

    // directed stimulus row: result is typed in only where fixed is set
    typedef struct {
        logic       req;
        logic [7:0] smp;
        bit         fixed;
        drive_out_t res;
    } step_row_t;

    // receiver behaviour, reselected each time the 8-bit ready_cycle counter wraps
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_PATTERN,
        RDY_RANDOM
    } ready_mode_t;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic       s_req_type = REQ_SAMPLE;
    logic [7:0] s_sample   = 8'd0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic       m_enable;
    logic       m_forward;
    logic       m_reverse;
    logic [7:0] m_duty;
    logic       cfg_wr_en  = 1'b0;
    logic [2:0] cfg_index  = CFG_SETPOINT;
    logic [7:0] cfg_wdata  = 8'd0;

    incremental_pid_pwm_motor_drive #(
        .PWM_PERIOD (PWM_PERIOD)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_enable   (m_enable),
        .m_forward  (m_forward),
        .m_reverse  (m_reverse),
        .m_duty     (m_duty),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // controller mirror: configuration and state kept alongside the block
    // ------------------------------------------------------------------
    logic [7:0] cur_setpoint;
    pid_cfg_t   cur_cfg;
    err_hist_t  err_hist;
    logic [7:0] duty_now;
    pwm_state_t pwm;
    logic       dir_fwd;
    logic       dir_rev;

    drive_out_t expected_q [$];
    int         fail_count = 0;
    int         burst_left = 0;

    // incremental pid on the error magnitude
    function automatic void pid_step(input int unsigned err);
        int e0, e1, e2, kp, ki, kd, up, down;
        // large error: full drive, history left alone
        if (err > cur_cfg.error_gate) begin
            duty_now = 8'(PWM_PERIOD);
            return;
        end
        err_hist.err_prev2 = err_hist.err_prev;
        err_hist.err_prev  = err_hist.err_now;
        err_hist.err_now   = err[5:0];
        e0 = err_hist.err_now;
        e1 = err_hist.err_prev;
        e2 = err_hist.err_prev2;
        kp = cur_cfg.gain_p;
        ki = cur_cfg.gain_i;
        kd = cur_cfg.gain_d;
        // positive and negative terms kept apart, as unsigned sums
        up   = ki * e0 + int'(duty_now);
        down = 0;
        if (e0 > e1)
            up += kp * (e0 - e1);
        else
            down += kp * (e1 - e0);
        if (e0 + e2 > 2 * e1)
            up += kd * (e0 + e2 - 2 * e1);
        else
            down += kd * (2 * e1 - e0 - e2);
        // sum not positive: drive is held
        if (up > down)
            duty_now = (up - down < PWM_PERIOD) ? 8'(up - down) : 8'(PWM_PERIOD);
    endfunction

    // advance the mirror by one transfer and return what the block should send
    function automatic drive_out_t predict_drive(input logic req, input logic [7:0] smp);
        drive_out_t r;
        if (req == REQ_SAMPLE) begin
            if (cur_setpoint >= smp) begin
                pid_step(int'(cur_setpoint) - int'(smp));
                dir_fwd = 1'b1;
                dir_rev = 1'b0;
            end else begin
                pid_step(int'(smp) - int'(cur_setpoint));
                dir_fwd = 1'b0;
                dir_rev = 1'b1;
            end
        end else begin
            pwm.tick_count   = pwm.tick_count + 8'd1;
            pwm.enable_level = (pwm.tick_count <= duty_now);
            // end of pwm period: level flips and the counter restarts
            if (pwm.tick_count == 8'(PWM_PERIOD)) begin
                pwm.enable_level = ~pwm.enable_level;
                pwm.tick_count   = 8'd0;
            end
        end
        r.enable  = pwm.enable_level;
        r.forward = dir_fwd;
        r.reverse = dir_rev;
        r.duty    = duty_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // directed rows, run straight after reset with the reset register values
    // ------------------------------------------------------------------
    step_row_t step_table [0:N_DIRECTED-1] = '{
        // first tick after reset: counter 1 above a zero drive
        '{REQ_TICK,   8'd0,   1'b1, '{1'b0, 1'b0, 1'b0, 8'd0}},
        // far below and far above the setpoint: full drive
        '{REQ_SAMPLE, 8'd0,   1'b1, '{1'b0, 1'b1, 1'b0, 8'd20}},
        '{REQ_SAMPLE, 8'd255, 1'b1, '{1'b0, 1'b0, 1'b1, 8'd20}},
        // tick while full drive, sample field ignored
        '{REQ_TICK,   8'd255, 1'b1, '{1'b1, 1'b0, 1'b1, 8'd20}},
        // exactly on setpoint: zero error, drive held at the period
        '{REQ_SAMPLE, 8'd171, 1'b1, '{1'b1, 1'b1, 1'b0, 8'd20}},
        // error right at the gate, reverse then forward
        '{REQ_SAMPLE, 8'd191, 1'b0, '0},
        '{REQ_SAMPLE, 8'd151, 1'b0, '0},
        // one past the gate, both sides
        '{REQ_SAMPLE, 8'd192, 1'b0, '0},
        '{REQ_SAMPLE, 8'd150, 1'b0, '0},
        // error dropping hard: negative terms swamp the drive
        '{REQ_SAMPLE, 8'd171, 1'b0, '0},
        '{REQ_SAMPLE, 8'd171, 1'b0, '0},
        '{REQ_SAMPLE, 8'd170, 1'b0, '0},
        '{REQ_SAMPLE, 8'd172, 1'b0, '0},
        '{REQ_TICK,   8'hAA,  1'b0, '0},
        '{REQ_TICK,   8'h55,  1'b0, '0},
        '{REQ_SAMPLE, 8'd161, 1'b0, '0},
        '{REQ_SAMPLE, 8'd181, 1'b0, '0},
        '{REQ_SAMPLE, 8'd171, 1'b0, '0},
        '{REQ_TICK,   8'hFF,  1'b0, '0},
        '{REQ_TICK,   8'h00,  1'b0, '0},
        '{REQ_SAMPLE, 8'd176, 1'b0, '0},
        '{REQ_TICK,   8'h0F,  1'b0, '0}
    };

    task automatic note_failure(input string what, input drive_out_t want,
                                input drive_out_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s exp en=%b fwd=%b rev=%b duty=%0d got en=%b fwd=%b rev=%b duty=%0d",
                     $realtime, what, want.enable, want.forward, want.reverse, want.duty,
                     got.enable, got.forward, got.reverse, got.duty);
    endtask

    // one input transfer; bursts of random length, random gaps between them
    task automatic send_step(input logic req, input logic [7:0] smp, input bit fixed,
                             input drive_out_t fixed_res);
        drive_out_t want;
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_sample   <= smp;
        do @(posedge aclk); while (!s_ready);
        want = predict_drive(req, smp);
        expected_q.push_back(fixed ? fixed_res : want);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            // now and then a long stretch without gaps
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    // drop valid and let every outstanding result drain
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_SETPOINT:   cur_setpoint       = val;
            CFG_ERROR_GATE: cur_cfg.error_gate = val[5:0];
            CFG_GAIN_P:     cur_cfg.gain_p     = val;
            CFG_GAIN_I:     cur_cfg.gain_i     = val;
            CFG_GAIN_D:     cur_cfg.gain_d     = val;
            default: ;
        endcase
    endtask

    // ticks and samples near the setpoint in equal share, the samples mostly taking the pid path,
    // plus samples anywhere in range
    task automatic run_random(input int n_items);
        int         pick, off, v;
        logic [7:0] smp;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                send_step(REQ_TICK, 8'($urandom), 1'b0, '0);
            end else begin
                if (pick < 8) begin
                    off = int'($urandom_range(0, 2 * cur_cfg.error_gate + 4))
                          - (int'(cur_cfg.error_gate) + 2);
                    v = int'(cur_setpoint) + off;
                    smp = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
                end else begin
                    smp = 8'($urandom);
                end
                send_step(REQ_SAMPLE, smp, 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result side: stall pattern and scoreboard
    // ------------------------------------------------------------------
    ready_mode_t ready_mode  = RDY_ALWAYS;
    logic [15:0] ready_pat   = 16'h0001;
    logic [7:0]  ready_cycle = 8'd0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            ready_cycle <= 8'd0;
        end else begin
            ready_cycle <= ready_cycle + 8'd1;
            if (ready_cycle == 8'd0) begin
                ready_mode <= ready_mode_t'($urandom_range(0, 2));
                // keep at least one ready bit so a stall never lasts forever
                ready_pat  <= 16'($urandom) | 16'h0001;
                m_ready    <= 1'b1;
            end else begin
                case (ready_mode)
                    RDY_ALWAYS:  m_ready <= 1'b1;
                    RDY_PATTERN: begin
                        m_ready   <= ready_pat[0];
                        ready_pat <= {ready_pat[0], ready_pat[15:1]};
                    end
                    default:     m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : result_check
        drive_out_t got;
        drive_out_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_enable, m_forward, m_reverse, m_duty};
            if (expected_q.size() == 0) begin
                note_failure("result with nothing outstanding:", '0, got);
            end else begin
                want = expected_q.pop_front();
                if (got.enable !== want.enable || got.forward !== want.forward ||
                    got.reverse !== want.reverse || got.duty !== want.duty)
                    note_failure("result mismatch:", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] sp, kp, ki, kd;
        logic [5:0] gate;

        cur_setpoint       = SETPOINT_RST;
        cur_cfg.error_gate = ERROR_GATE_RST;
        cur_cfg.gain_p     = GAIN_P_RST;
        cur_cfg.gain_i     = GAIN_I_RST;
        cur_cfg.gain_d     = GAIN_D_RST;
        err_hist           = '0;
        duty_now           = 8'd0;
        pwm.tick_count     = 8'd0;
        pwm.enable_level   = 1'b1;
        dir_fwd            = 1'b0;
        dir_rev            = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (step_table[i])
            send_step(step_table[i].req, step_table[i].smp, step_table[i].fixed,
                      step_table[i].res);
        run_random(100);

        for (int ph = 0; ph < N_CFG_PHASES; ph++) begin
            case (ph)
                0: begin sp = 8'd0;   gate = 6'd0;  kp = 8'd0;   ki = 8'd0;   kd = 8'd0;   end
                1: begin sp = 8'd255; gate = 6'd63; kp = 8'd255; ki = 8'd255; kd = 8'd255; end
                2: begin sp = 8'd128; gate = 6'd63; kp = 8'd1;   ki = 8'd0;   kd = 8'd2;   end
                3: begin sp = 8'd40;  gate = 6'd8;  kp = 8'd0;   ki = 8'd1;   kd = 8'd0;   end
                default: begin
                    // small gains mostly, so the drive settles below the period
                    sp   = 8'($urandom);
                    gate = 6'($urandom_range(0, 63));
                    kp   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
                    ki   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
                    kd   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
                end
            endcase
            drain_results();
            write_reg(CFG_SETPOINT, sp);
            write_reg(CFG_ERROR_GATE, {2'b00, gate});
            write_reg(CFG_GAIN_P, kp);
            write_reg(CFG_GAIN_I, ki);
            write_reg(CFG_GAIN_D, kd);
            cfg_wr_en <= 1'b0;
            run_random(PHASE_ITEMS);
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("incremental_pid_pwm_motor_drive_test OK");
        else
            $display("incremental_pid_pwm_motor_drive_test NOT OK");
        $finish;
    end

    // watchdog, well beyond the slowest correct run
    initial begin
        #5ms;
        $display("incremental_pid_pwm_motor_drive_test NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ipd_pkg.sv
rtl/core/ipd_pid.sv
rtl/core/ipd_pwm.sv
rtl/core/incremental_pid_pwm_motor_drive.sv
tb/incremental_pid_pwm_motor_drive_test.sv
